// ===== hdl/wma_pkg.sv =====
// Shared constants and types of the weighted moving average block.
package wma_pkg;

	localparam int CHANNEL_W = 2;
	localparam int SAMPLE_W = 16;
	localparam int WINDOW_W = 8;

	localparam int DEF_CHANNELS = 3;
	localparam int DEF_MAX_WINDOW = 255;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 8'd25;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_DIV,
		ST_FIN
	} wma_state_t;

endpackage

// ===== hdl/wma_if.sv =====
// Channel interfaces of the weighted moving average block.
interface wma_sample_if;
	logic valid;
	logic ready;
	logic [wma_pkg::CHANNEL_W-1:0] channel;
	logic signed [wma_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output channel, output sample, input ready);
	modport sink (input valid, input channel, input sample, output ready);
endinterface

interface wma_result_if;
	logic valid;
	logic ready;
	logic signed [wma_pkg::SAMPLE_W-1:0] filtered;

	modport source (output valid, output filtered, input ready);
	modport sink (input valid, input filtered, output ready);
endinterface

interface wma_cfg_if;
	logic valid;
	logic ready;
	logic [wma_pkg::WINDOW_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/wma_div.sv =====
// Restoring divider, one quotient bit per cycle, for a quotient known to fit SAMPLE_W bits.
module wma_div #(
	parameter int DSR_W = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [DSR_W+wma_pkg::SAMPLE_W-1:0]          dividend,
	input  logic [DSR_W-1:0]                            divisor,
	output logic                                        done,
	output logic [wma_pkg::SAMPLE_W-1:0]                quotient
);
	import wma_pkg::*;

	localparam int Q_W = SAMPLE_W;
	localparam int DVD_W = DSR_W + Q_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DSR_W-1:0]   rem_q;
	logic [DSR_W-1:0]   dsr_q;
	logic [Q_W-1:0]     lo_q;
	logic [DSR_W:0]     trial;
	logic [DSR_W:0]     diff;
	logic               fits;

	// The remainder stays below the divisor, so one extra bit holds the trial value.
	assign trial = {rem_q, lo_q[Q_W-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign fits = (trial >= {1'b0, dsr_q});

	assign done = busy_q && (cnt_q == CNT_W'(1));
	assign quotient = lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(Q_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DVD_W-1:Q_W];
			lo_q <= dividend[Q_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
			lo_q <= {lo_q[Q_W-2:0], fits};
		end
	end

endmodule

// ===== hdl/weighted_moving_average_multichannel.sv =====
// Linearly weighted moving average over several channel histories held in one memory.
//
//   channel    role      carries
//   cfg        sink      data: window length N
//   samples    sink      channel, sample (signed Q8.8)
//   averages   source    filtered (signed Q8.8, rounded half up)
//
// An item passes through idle, the issue sequence (N-1 history reads, then the new
// sample), the drain of the multiply-accumulate, the division and the load of the
// output register; a sample for an absent channel goes from idle straight to that load.
// After reset a clearing pass over all CHANNELS*MAX_WINDOW entries zeroes the history;
// samples is not ready until it ends, cfg always is. A finished result waits in the
// output register while the next transaction on samples is taken.
module weighted_moving_average_multichannel #(
	parameter int CHANNELS = wma_pkg::DEF_CHANNELS,
	parameter int MAX_WINDOW = wma_pkg::DEF_MAX_WINDOW
) (
	input  logic          clk,
	input  logic          arst_n,
	wma_cfg_if.sink       cfg,
	wma_sample_if.sink    samples,
	wma_result_if.source  averages
);
	import wma_pkg::*;

	localparam int MEM_DEPTH = CHANNELS * MAX_WINDOW;
	localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int NW = WINDOW_W;
	localparam int DEN_W = $clog2(MAX_WINDOW * (MAX_WINDOW + 1) / 2 + 1);
	localparam int ACC_W = SAMPLE_W + DEN_W;
	localparam int PROD_W = SAMPLE_W + NW + 1;
	localparam int DSR_W = DEN_W + 1;
	localparam int DVD_W = DSR_W + SAMPLE_W;

	wma_state_t state_q, state_d;

	logic [NW-1:0]              window_q;
	logic [NW-1:0]              n_sat;
	logic                       ch_bad;
	logic                       accept;

	logic [AW-1:0]              clr_q;
	logic [AW-1:0]              base_q;
	logic signed [SAMPLE_W-1:0] smp_q;
	logic [NW-1:0]              n_q;
	logic                       zero_res_q;
	logic [NW-1:0]              rd_left_q;
	logic [NW-1:0]              j_q;
	logic [NW-1:0]              w_q;
	logic [DEN_W-1:0]           den_q;

	logic                       v_s1_q;
	logic                       smp_term_s1;
	logic [NW-1:0]              w_s1;
	logic [AW-1:0]              wa_s1;
	logic                       v_s2_q;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;

	logic [SAMPLE_W-1:0]        mem [MEM_DEPTH];
	logic [SAMPLE_W-1:0]        rdata_q;
	logic                       mem_we;
	logic [AW-1:0]              mem_wa;
	logic [SAMPLE_W-1:0]        mem_wd;
	logic [SAMPLE_W-1:0]        operand;

	logic                       clr_on;
	logic                       issue_rd;
	logic                       issue_smp;
	logic                       drained;
	logic                       div_start;
	logic                       load_out;

	logic [DVD_W-1:0]           num2;
	logic [DVD_W-1:0]           bias;
	logic [DVD_W-1:0]           dividend;
	logic                       div_done;
	logic [SAMPLE_W-1:0]        quot;

	logic                       out_valid_q;
	logic [SAMPLE_W-1:0]        out_q;

	assign cfg.ready = 1'b1;
	assign samples.ready = (state_q == ST_IDLE);
	assign accept = samples.valid && samples.ready;
	assign averages.valid = out_valid_q;
	assign averages.filtered = out_q;

	assign n_sat = (32'(window_q) > MAX_WINDOW) ? NW'(MAX_WINDOW) : window_q;
	assign ch_bad = (32'(samples.channel) >= CHANNELS);
	assign drained = !v_s1_q && !v_s2_q;

	// Control strobes.
	always_comb begin
		clr_on = 1'b0;
		issue_rd = 1'b0;
		issue_smp = 1'b0;
		div_start = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_CLEAR: clr_on = 1'b1;
			ST_ISSUE: begin
				issue_rd = (rd_left_q != '0);
				issue_smp = (rd_left_q == '0);
			end
			ST_DRAIN: div_start = drained && !zero_res_q;
			ST_FIN: load_out = !out_valid_q || averages.ready;
			default: ;
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(MEM_DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ch_bad ? ST_FIN : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (issue_smp) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drained) state_d = zero_res_q ? ST_FIN : ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (load_out) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			window_q <= WINDOW_RESET;
			clr_q <= '0;
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) window_q <= cfg.data;
			if (clr_on) clr_q <= clr_q + AW'(1);
			v_s1_q <= issue_rd || issue_smp;
			v_s2_q <= v_s1_q;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (averages.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item setup and the read sequence: stored entries from the oldest in the
	// window down to the newest, then the new sample with the full weight.
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= AW'(32'(samples.channel) * MAX_WINDOW);
			smp_q <= samples.sample;
			n_q <= n_sat;
			zero_res_q <= ch_bad || (n_sat == '0);
			rd_left_q <= (n_sat == '0) ? '0 : n_sat - NW'(1);
			j_q <= n_sat - NW'(2);
			w_q <= NW'(1);
			den_q <= '0;
			acc_q <= '0;
		end else begin
			if (issue_rd) begin
				rd_left_q <= rd_left_q - NW'(1);
				j_q <= j_q - NW'(1);
				w_q <= w_q + NW'(1);
				den_q <= den_q + DEN_W'(w_q);
			end else if (issue_smp) begin
				den_q <= den_q + DEN_W'(n_q);
			end
			if (v_s2_q) acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (issue_rd || issue_smp) begin
			smp_term_s1 <= issue_smp;
			w_s1 <= issue_smp ? n_q : w_q;
			wa_s1 <= issue_smp ? base_q : base_q + AW'(j_q) + AW'(1);
		end
		if (v_s1_q) prod_s2 <= PROD_W'($signed(operand) * $signed({1'b0, w_s1}));
		if (load_out) begin
			out_q <= zero_res_q ? '0 : {~quot[SAMPLE_W-1], quot[SAMPLE_W-2:0]};
		end
	end

	// Each entry read moves up by one place as it passes through the multiplier.
	assign operand = smp_term_s1 ? smp_q : rdata_q;
	assign mem_we = clr_on || v_s1_q;
	assign mem_wa = clr_on ? clr_q : wa_s1;
	assign mem_wd = clr_on ? '0 : operand;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (issue_rd) rdata_q <= mem[base_q + AW'(j_q)];
	end

	// Offsetting by 2^(SAMPLE_W-1) times the divisor keeps the dividend positive;
	// the offset comes back out as an inverted top bit of the quotient.
	assign num2 = DVD_W'(acc_q) << 1;
	assign bias = (DVD_W'(den_q) << SAMPLE_W) + DVD_W'(den_q);
	assign dividend = num2 + bias;

	wma_div #(
		.DSR_W(DSR_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({den_q, 1'b0}),
		.done     (div_done),
		.quotient (quot)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the multichannel weighted moving average block.
module testbench;
	import wma_pkg::*;

	typedef enum logic {ROW_CONFIG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic [CHANNEL_W-1:0] channel;
		logic [SAMPLE_W-1:0] value;
		logic typed;
		logic [SAMPLE_W-1:0] result;
	} stim_row_t;

	localparam logic [CHANNEL_W-1:0] OUTSIDE_CHANNEL = 2'd3;
	localparam int DIRECTED_ROWS = 24;
	localparam int RANDOM_PHASES = 12;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 800;
	localparam int DRAIN_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	wma_cfg_if cfg_bus ();
	wma_sample_if sample_bus ();
	wma_result_if average_bus ();

	weighted_moving_average_multichannel dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_bus),
		.samples(sample_bus),
		.averages(average_bus)
	);

	logic signed [SAMPLE_W-1:0] sample_history [DEF_CHANNELS][DEF_MAX_WINDOW];
	logic [WINDOW_W-1:0] window_n;
	logic signed [SAMPLE_W-1:0] averages_due [$];
	stim_row_t directed [DIRECTED_ROWS];
	int failures = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;
	bit hold_averages = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shifts the channel history within the window and returns the rounded weighted mean.
	function automatic logic signed [SAMPLE_W-1:0] weighted_average(
		input logic [CHANNEL_W-1:0] ch,
		input logic signed [SAMPLE_W-1:0] value
	);
		int n;
		int i;
		longint acc;
		longint den;
		longint top;
		longint q;
		if (ch >= DEF_CHANNELS)
			return '0;
		n = window_n;
		if (n > DEF_MAX_WINDOW)
			n = DEF_MAX_WINDOW;
		for (i = n - 1; i > 0; i--)
			sample_history[ch][i] = sample_history[ch][i-1];
		sample_history[ch][0] = value;
		if (n == 0)
			return '0;
		acc = 0;
		for (i = 0; i < n; i++)
			acc += longint'(sample_history[ch][i]) * longint'(n - i);
		den = longint'(n) * longint'(n + 1) / 2;
		// Half up is floor((2*acc + den) / (2*den)); division truncates toward zero.
		top = 2 * acc + den;
		q = top / (2 * den);
		if ((top % (2 * den)) != 0 && top < 0)
			q = q - 1;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return q[SAMPLE_W-1:0];
	endfunction

	task automatic offer_sample(
		input logic [CHANNEL_W-1:0] ch,
		input logic [SAMPLE_W-1:0] value,
		input logic typed,
		input logic [SAMPLE_W-1:0] result
	);
		logic signed [SAMPLE_W-1:0] predicted;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			sample_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.channel <= ch;
		sample_bus.sample <= value;
		do @(posedge clk); while (sample_bus.ready !== 1'b1);
		predicted = weighted_average(ch, value);
		averages_due.push_back(typed ? result : predicted);
	endtask

	// The window only changes once every outstanding average has come out.
	task automatic write_window(input logic [WINDOW_W-1:0] n);
		sample_bus.valid <= 1'b0;
		do @(posedge clk); while (averages_due.size() != 0);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= n;
		do @(posedge clk); while (cfg_bus.ready !== 1'b1);
		cfg_bus.valid <= 1'b0;
		window_n = n;
	endtask

	initial begin
		int k;
		int phase;
		int items;
		logic [WINDOW_W-1:0] n;
		logic [CHANNEL_W-1:0] ch;
		logic [SAMPLE_W-1:0] value;

		arst_n <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.data <= '0;
		sample_bus.valid <= 1'b0;
		sample_bus.channel <= '0;
		sample_bus.sample <= '0;
		for (int c = 0; c < DEF_CHANNELS; c++)
			for (int p = 0; p < DEF_MAX_WINDOW; p++)
				sample_history[c][p] = '0;
		window_n = WINDOW_RESET;

		directed[0] = '{ROW_SAMPLE, 2'd0, 16'h0000, 1'b1, 16'h0000};
		directed[1] = '{ROW_SAMPLE, 2'd1, 16'h0D00, 1'b1, 16'h0100};
		directed[2] = '{ROW_SAMPLE, OUTSIDE_CHANNEL, 16'h7FFF, 1'b1, 16'h0000};
		directed[3] = '{ROW_CONFIG, 2'd0, 16'd1, 1'b0, 16'h0000};
		directed[4] = '{ROW_SAMPLE, 2'd0, 16'h7FFF, 1'b1, 16'h7FFF};
		directed[5] = '{ROW_SAMPLE, 2'd1, 16'h8000, 1'b1, 16'h8000};
		directed[6] = '{ROW_SAMPLE, 2'd2, 16'hFFFF, 1'b1, 16'hFFFF};
		directed[7] = '{ROW_SAMPLE, 2'd2, 16'h0001, 1'b1, 16'h0001};
		directed[8] = '{ROW_SAMPLE, OUTSIDE_CHANNEL, 16'h8000, 1'b1, 16'h0000};
		directed[9] = '{ROW_CONFIG, 2'd0, 16'd0, 1'b0, 16'h0000};
		directed[10] = '{ROW_SAMPLE, 2'd0, 16'h1234, 1'b1, 16'h0000};
		directed[11] = '{ROW_SAMPLE, 2'd1, 16'h8000, 1'b1, 16'h0000};
		directed[12] = '{ROW_SAMPLE, 2'd2, 16'h7FFF, 1'b1, 16'h0000};
		directed[13] = '{ROW_CONFIG, 2'd0, 16'd2, 1'b0, 16'h0000};
		directed[14] = '{ROW_SAMPLE, 2'd0, 16'h00FF, 1'b0, 16'h0000};
		directed[15] = '{ROW_SAMPLE, 2'd1, 16'h7FFF, 1'b0, 16'h0000};
		directed[16] = '{ROW_CONFIG, 2'd0, 16'd255, 1'b0, 16'h0000};
		directed[17] = '{ROW_SAMPLE, 2'd2, 16'h8000, 1'b0, 16'h0000};
		directed[18] = '{ROW_SAMPLE, 2'd2, 16'h8000, 1'b0, 16'h0000};
		directed[19] = '{ROW_SAMPLE, 2'd0, 16'h7FFF, 1'b0, 16'h0000};
		directed[20] = '{ROW_CONFIG, 2'd0, 16'd3, 1'b0, 16'h0000};
		directed[21] = '{ROW_SAMPLE, 2'd1, 16'h0003, 1'b0, 16'h0000};
		directed[22] = '{ROW_SAMPLE, 2'd1, 16'hFFFD, 1'b0, 16'h0000};
		directed[23] = '{ROW_SAMPLE, 2'd1, 16'h0000, 1'b0, 16'h0000};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < DIRECTED_ROWS; k++) begin
			if (directed[k].kind == ROW_CONFIG) begin
				write_window(directed[k].value[WINDOW_W-1:0]);
			end else begin
				offer_sample(directed[k].channel, directed[k].value, directed[k].typed,
					directed[k].result);
			end
		end

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: n = 8'd4;
				1: n = 8'd255;
				2: n = 8'd0;
				3: n = 8'd1;
				default: begin
					if ($urandom_range(0, 3) == 0)
						n = 8'($urandom_range(21, 254));
					else
						n = 8'($urandom_range(2, 20));
				end
			endcase
			gaps_on = (phase < RANDOM_PHASES - 2);
			write_window(n);
			// Long stall on the averages side so the block backs up into its input.
			if (phase == 4)
				hold_averages = 1'b1;
			items = (phase == 1) ? 30 : 55;
			for (k = 0; k < items; k++) begin
				ch = ($urandom_range(0, 19) == 0) ? OUTSIDE_CHANNEL : 2'($urandom_range(0, 2));
				case ($urandom_range(0, 9))
					0: value = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
					1, 2, 3: value = 16'($urandom_range(0, 8)) - 16'd4;
					default: value = 16'($urandom);
				endcase
				offer_sample(ch, value, 1'b0, '0);
			end
		end

		sample_bus.valid <= 1'b0;
		while (averages_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && averages_due.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		average_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_averages) begin
				hold_averages = 1'b0;
				average_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				average_bus.ready <= 1'b1;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				average_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				average_bus.ready <= 1'b1;
			end else begin
				average_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_averages
		logic signed [SAMPLE_W-1:0] want;
		if (average_bus.valid === 1'b1 && average_bus.ready === 1'b1) begin
			if (averages_due.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("average %0d with no sample outstanding", average_bus.filtered);
			end else begin
				want = averages_due.pop_front();
				if (average_bus.filtered !== want) begin
					failures++;
					if (failures <= 10)
						$display("average mismatch: expected %0d, got %0d", want,
							average_bus.filtered);
				end
			end
		end
	end

	// A transaction on any channel restarts the count.
	always @(posedge clk) begin
		if ((sample_bus.valid === 1'b1 && sample_bus.ready === 1'b1) ||
				(average_bus.valid === 1'b1 && average_bus.ready === 1'b1) ||
				(cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
